>>> sv/ppm_pkg.sv
package ppm_pkg;

    // fixed field widths
    localparam int RAW_W  = 12;
    localparam int Q15_W  = 16;
    localparam int SM_W   = 24;
    localparam int TIME_W = 32;
    localparam int LIM_W  = 16;
    localparam int COEF_W = 8;
    localparam int PROD_W = 32;

    // quotient bits of a normalised position strictly inside the span
    localparam int Q_BITS = 15;
    localparam int CNT_W  = $clog2(Q_BITS + 1);

    localparam logic [Q15_W-1:0] FULL_Q15 = 16'h8000;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_CHAN_A_MIN      = 3'd0,
        CFG_CHAN_A_MAX      = 3'd1,
        CFG_CHAN_B_MIN      = 3'd2,
        CFG_CHAN_B_MAX      = 3'd3,
        CFG_PRESSURE_LIMIT  = 3'd4,
        CFG_DEVIATION_LIMIT = 3'd5,
        CFG_CONFLICT_GRACE  = 3'd6,
        CFG_BRAKE_GRACE     = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP_A,
        S_DIV_A,
        S_PREP_B,
        S_DIV_B,
        S_FA_KEEP,
        S_FA_ADD,
        S_FB_KEEP,
        S_FB_ADD,
        S_FB_STORE,
        S_CONFLICT,
        S_BRAKE
    } t_state;

    typedef enum logic [1:0] {
        NK_ZERO,
        NK_FULL,
        NK_DIVIDE
    } t_norm_kind;

    typedef struct packed {
        t_norm_kind       kind;
        logic [RAW_W-1:0] num;
        logic [RAW_W-1:0] den;
    } t_norm_prep;

    typedef enum logic [1:0] {
        MAC_NONE,
        MAC_KEEP,
        MAC_ADD
    } t_mac_op;

    typedef struct packed {
        t_mac_op           op;
        logic [COEF_W-1:0] coef;
        logic [SM_W-1:0]   opnd;
    } t_mac_req;

    typedef struct packed {
        logic             start;
        logic [RAW_W-1:0] num;
        logic [RAW_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [Q_BITS-1:0] quo;
    } t_div_stat;

endpackage

>>> sv/ppm_serial_div.sv
// restoring divider, one quotient bit per cycle, num < den assumed
module ppm_serial_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppm_pkg::t_div_req   i_req,
    output ppm_pkg::t_div_stat  o_stat
);
    import ppm_pkg::*;

    logic [RAW_W-1:0]  r_rem, n_rem;
    logic [RAW_W-1:0]  r_den, n_den;
    logic [Q_BITS-1:0] r_quo, n_quo;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [RAW_W:0]    trial;
    logic [RAW_W:0]    trial_sub;

    always_comb begin
        n_rem     = r_rem;
        n_den     = r_den;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_busy    = r_busy;
        n_done    = 1'b0;
        trial     = {r_rem, 1'b0};
        trial_sub = trial - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = i_req.num;
            n_den  = i_req.den;
            n_quo  = '0;
            n_cnt  = CNT_W'(Q_BITS);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_den}) begin
                n_rem = trial_sub[RAW_W-1:0];
                n_quo = {r_quo[Q_BITS-2:0], 1'b1};
            end else begin
                n_rem = trial[RAW_W-1:0];
                n_quo = {r_quo[Q_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_stat.done = r_done;
    assign o_stat.quo  = r_quo;

endmodule

>>> sv/ppm_filter_mac.sv
// shared multiplier for the low-pass filters: keep term, then add term
module ppm_filter_mac (
    input  logic              i_clk,
    input  ppm_pkg::t_mac_req i_req,
    output logic [23:0]       o_acc
);
    import ppm_pkg::*;

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] rounded;
    logic [SM_W-1:0]   r_acc, n_acc;

    assign prod    = PROD_W'(i_req.coef) * PROD_W'(i_req.opnd);
    assign rounded = prod + PROD_W'(128);

    always_comb begin
        case (i_req.op)
            MAC_KEEP: n_acc = rounded[SM_W+7:8];
            MAC_ADD:  n_acc = prod[SM_W-1:0] + r_acc;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

>>> sv/pedal_plausibility_monitor_top.sv
// Pedal plausibility monitor. Each request carries two accelerator pedal
// sensor samples (direct and inverse), a brake pressure sample and a
// millisecond time stamp, and yields exactly one result: both filtered pedal
// positions, their mean and the torque demand in Q1.15 (32768 = full travel),
// plus the sensor fault and brake latch flags. Processing is sequential: each
// channel whose reading lies strictly inside its calibrated span passes
// through the shared 15-step restoring divider; a channel whose reading is
// at or beyond either end of its span, or whose span is zero, skips the
// divider. Input stall stays high from acceptance until the result register
// is loaded. The result sits in an output register, so the next request is
// taken while an earlier result waits downstream. Configuration is written
// through a plain write port; the user must write it only while the block is
// idle, which the block itself does not enforce.
module pedal_plausibility_monitor_top #(
    parameter int ADC_BITS      = 12,
    parameter int ALPHA_Q8      = 51,
    parameter int ENGAGE_LEVEL  = 8192,
    parameter int RELEASE_LEVEL = 1638
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // sample request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [11:0] i_raw_a,
    input  logic [11:0] i_raw_b,
    input  logic [11:0] i_raw_pressure,
    input  logic [31:0] i_now_ms,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_filtered_a,
    output logic [15:0] o_filtered_b,
    output logic [15:0] o_pedal_mean,
    output logic [15:0] o_torque_demand,
    output logic        o_sensor_fault,
    output logic        o_brake_fault
);
    import ppm_pkg::*;

    // only the low adc bits of each count are significant
    localparam int               USE_BITS = (ADC_BITS < RAW_W) ? ADC_BITS : RAW_W;
    localparam logic [RAW_W-1:0] ADC_MASK = RAW_W'((1 << USE_BITS) - 1);
    localparam logic [COEF_W-1:0] COEF_X    = COEF_W'(ALPHA_Q8);
    localparam logic [COEF_W-1:0] COEF_KEEP = COEF_W'(256 - ALPHA_Q8);
    localparam logic [Q15_W:0]    ENGAGE_Q  = (Q15_W + 1)'(ENGAGE_LEVEL);
    localparam logic [Q15_W:0]    RELEASE_Q = (Q15_W + 1)'(RELEASE_LEVEL);

    // signed span setup of one sensor, swapped calibration folded in
    function automatic t_norm_prep norm_prep(input logic [RAW_W-1:0] raw,
                                             input logic [RAW_W-1:0] lo,
                                             input logic [RAW_W-1:0] hi);
        t_norm_prep        p;
        logic signed [RAW_W:0] num;
        logic signed [RAW_W:0] den;
        num    = $signed({1'b0, raw}) - $signed({1'b0, lo});
        den    = $signed({1'b0, hi}) - $signed({1'b0, lo});
        p.kind = NK_ZERO;
        p.num  = '0;
        p.den  = '0;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (den == 0 || num <= 0) begin
            p.kind = NK_ZERO;
        end else if (num >= den) begin
            p.kind = NK_FULL;
        end else begin
            p.kind = NK_DIVIDE;
            p.num  = num[RAW_W-1:0];
            p.den  = den[RAW_W-1:0];
        end
        return p;
    endfunction

    // configuration registers
    logic [RAW_W-1:0]  r_a_min, r_a_max, r_b_min, r_b_max, r_p_limit;
    logic [LIM_W-1:0]  r_dev_limit, r_c_grace, r_b_grace;

    // sequencer
    t_state r_state, n_state;

    // captured request
    logic [RAW_W-1:0]  r_raw_a, r_raw_b, r_raw_p;
    logic [TIME_W-1:0] r_now;

    // normalised positions and filter state
    logic [Q15_W-1:0]  r_pos_a, r_pos_b;
    logic [SM_W-1:0]   r_smooth_a, r_smooth_b;

    // plausibility state
    logic [TIME_W-1:0] r_c_start, n_c_start;
    logic              r_c_seen, n_c_seen;
    logic              r_fault, n_fault;
    logic              r_cut, n_cut;
    logic [TIME_W-1:0] r_o_start, n_o_start;
    logic              r_o_seen, n_o_seen;
    logic              r_latch, n_latch;
    logic [Q15_W:0]    r_mean;

    // result register
    logic              r_out_valid;
    logic [Q15_W-1:0]  r_fa, r_fb, r_mean_out, r_torque;
    logic              r_fault_out, r_latch_out;

    // shared units
    t_div_req          div_req;
    t_div_stat         div_stat;
    t_mac_req          mac_req;
    logic [SM_W-1:0]   mac_acc;

    t_norm_prep        prep_a, prep_b;
    logic              b_span_zero;
    logic              in_take;
    logic              out_free;

    logic [SM_W-1:0]   diff;
    logic [SM_W-1:0]   dev_scaled;
    logic [TIME_W-1:0] c_elapsed, o_elapsed;
    logic [SM_W+1:0]   mean_sum;
    logic [SM_W:0]     fa_sum, fb_sum;
    logic [Q15_W-1:0]  torque_nx;
    logic              hard_brake;

    ppm_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_stat  (div_stat)
    );

    ppm_filter_mac u_mac (
        .i_clk (i_clk),
        .i_req (mac_req),
        .o_acc (mac_acc)
    );

    assign in_take     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);

    assign prep_a      = norm_prep(r_raw_a, r_a_min, r_a_max);
    assign prep_b      = norm_prep(r_raw_b, r_b_min, r_b_max);
    assign b_span_zero = (r_b_min == r_b_max);

    // configuration writes, counts masked to the adc width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_min     <= '0;
            r_a_max     <= RAW_W'(4095) & ADC_MASK;
            r_b_min     <= '0;
            r_b_max     <= RAW_W'(4095) & ADC_MASK;
            r_p_limit   <= RAW_W'(500) & ADC_MASK;
            r_dev_limit <= LIM_W'(3277);
            r_c_grace   <= LIM_W'(100);
            r_b_grace   <= LIM_W'(500);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CHAN_A_MIN:      r_a_min     <= i_cfg_data[RAW_W-1:0] & ADC_MASK;
                CFG_CHAN_A_MAX:      r_a_max     <= i_cfg_data[RAW_W-1:0] & ADC_MASK;
                CFG_CHAN_B_MIN:      r_b_min     <= i_cfg_data[RAW_W-1:0] & ADC_MASK;
                CFG_CHAN_B_MAX:      r_b_max     <= i_cfg_data[RAW_W-1:0] & ADC_MASK;
                CFG_PRESSURE_LIMIT:  r_p_limit   <= i_cfg_data[RAW_W-1:0] & ADC_MASK;
                CFG_DEVIATION_LIMIT: r_dev_limit <= i_cfg_data;
                CFG_CONFLICT_GRACE:  r_c_grace   <= i_cfg_data;
                CFG_BRAKE_GRACE:     r_b_grace   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (in_take) n_state = S_PREP_A;
            S_PREP_A:   n_state = (prep_a.kind == NK_DIVIDE) ? S_DIV_A : S_PREP_B;
            S_DIV_A:    if (div_stat.done) n_state = S_PREP_B;
            S_PREP_B: begin
                if (b_span_zero || prep_b.kind != NK_DIVIDE) begin
                    n_state = S_FA_KEEP;
                end else begin
                    n_state = S_DIV_B;
                end
            end
            S_DIV_B:    if (div_stat.done) n_state = S_FA_KEEP;
            S_FA_KEEP:  n_state = S_FA_ADD;
            S_FA_ADD:   n_state = S_FB_KEEP;
            S_FB_KEEP:  n_state = S_FB_ADD;
            S_FB_ADD:   n_state = S_FB_STORE;
            S_FB_STORE: n_state = S_CONFLICT;
            S_CONFLICT: n_state = S_BRAKE;
            S_BRAKE:    if (out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // unit control per state
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = prep_a.num;
        div_req.den   = prep_a.den;
        mac_req.op    = MAC_NONE;
        mac_req.coef  = COEF_KEEP;
        mac_req.opnd  = r_smooth_a;
        case (r_state)
            S_PREP_A: begin
                div_req.start = (prep_a.kind == NK_DIVIDE);
            end
            S_PREP_B: begin
                div_req.start = !b_span_zero && (prep_b.kind == NK_DIVIDE);
                div_req.num   = prep_b.num;
                div_req.den   = prep_b.den;
            end
            S_FA_KEEP: begin
                mac_req.op = MAC_KEEP;
            end
            S_FA_ADD: begin
                mac_req.op   = MAC_ADD;
                mac_req.coef = COEF_X;
                mac_req.opnd = SM_W'(r_pos_a);
            end
            S_FB_KEEP: begin
                mac_req.op   = MAC_KEEP;
                mac_req.opnd = r_smooth_b;
            end
            S_FB_ADD: begin
                mac_req.op   = MAC_ADD;
                mac_req.coef = COEF_X;
                mac_req.opnd = SM_W'(r_pos_b);
            end
            default: ;
        endcase
    end

    // sensor disagreement check on the freshly filtered positions
    assign diff       = (r_smooth_a > r_smooth_b) ? (r_smooth_a - r_smooth_b)
                                                  : (r_smooth_b - r_smooth_a);
    assign dev_scaled = {r_dev_limit, 8'd0};
    assign c_elapsed  = r_now - r_c_start;
    assign mean_sum   = (SM_W + 2)'(r_smooth_a) + (SM_W + 2)'(r_smooth_b)
                      + (SM_W + 2)'(256);

    always_comb begin
        n_c_start = r_c_start;
        n_c_seen  = r_c_seen;
        n_fault   = r_fault;
        n_cut     = 1'b0;
        if (diff > dev_scaled) begin
            if (!r_c_seen) begin
                n_c_start = r_now;
                n_c_seen  = 1'b1;
            end else if (c_elapsed > TIME_W'(r_c_grace)) begin
                n_fault = 1'b1;
                n_cut   = 1'b1;
            end
        end else begin
            n_c_seen = 1'b0;
            n_fault  = 1'b0;
        end
    end

    // brake plausibility latch, skipped while a confirmed fault cuts torque
    assign o_elapsed  = r_now - r_o_start;
    assign hard_brake = (r_raw_p > r_p_limit) && (r_mean > ENGAGE_Q);

    always_comb begin
        n_o_start = r_o_start;
        n_o_seen  = r_o_seen;
        n_latch   = r_latch;
        torque_nx = r_mean[Q15_W-1:0];
        if (r_cut) begin
            torque_nx = '0;
        end else begin
            if (!r_latch) begin
                if (hard_brake) begin
                    if (!r_o_seen) begin
                        n_o_start = r_now;
                        n_o_seen  = 1'b1;
                    end else if (o_elapsed > TIME_W'(r_b_grace)) begin
                        n_latch  = 1'b1;
                        n_o_seen = 1'b0;
                    end
                end else begin
                    n_o_seen = 1'b0;
                end
            end
            if (n_latch) begin
                if (r_mean < RELEASE_Q) begin
                    n_latch = 1'b0;
                end else begin
                    torque_nx = '0;
                end
            end
        end
    end

    assign fa_sum = (SM_W + 1)'(r_smooth_a) + (SM_W + 1)'(128);
    assign fb_sum = (SM_W + 1)'(r_smooth_b) + (SM_W + 1)'(128);

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_smooth_a  <= '0;
            r_smooth_b  <= '0;
            r_c_start   <= '0;
            r_c_seen    <= 1'b0;
            r_fault     <= 1'b0;
            r_cut       <= 1'b0;
            r_o_start   <= '0;
            r_o_seen    <= 1'b0;
            r_latch     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_FB_KEEP:  r_smooth_a <= mac_acc;
                S_FB_STORE: r_smooth_b <= mac_acc;
                S_CONFLICT: begin
                    r_c_start <= n_c_start;
                    r_c_seen  <= n_c_seen;
                    r_fault   <= n_fault;
                    r_cut     <= n_cut;
                end
                S_BRAKE: begin
                    if (out_free) begin
                        r_o_start <= n_o_start;
                        r_o_seen  <= n_o_seen;
                        r_latch   <= n_latch;
                    end
                end
                default: ;
            endcase
            // result register: loads on commit, empties when taken
            if (r_state == S_BRAKE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_raw_a <= i_raw_a & ADC_MASK;
            r_raw_b <= i_raw_b & ADC_MASK;
            r_raw_p <= i_raw_pressure & ADC_MASK;
            r_now   <= i_now_ms;
        end
        case (r_state)
            S_PREP_A: begin
                r_pos_a <= (prep_a.kind == NK_FULL) ? FULL_Q15 : '0;
            end
            S_DIV_A: begin
                if (div_stat.done) begin
                    r_pos_a <= {1'b0, div_stat.quo};
                end
            end
            S_PREP_B: begin
                // inverse sensor: position is full travel minus normalised value
                if (b_span_zero || prep_b.kind == NK_FULL) begin
                    r_pos_b <= '0;
                end else begin
                    r_pos_b <= FULL_Q15;
                end
            end
            S_DIV_B: begin
                if (div_stat.done) begin
                    r_pos_b <= FULL_Q15 - {1'b0, div_stat.quo};
                end
            end
            S_CONFLICT: begin
                r_mean <= mean_sum[SM_W+1:9];
            end
            S_BRAKE: begin
                if (out_free) begin
                    r_fa        <= fa_sum[SM_W-1:8];
                    r_fb        <= fb_sum[SM_W-1:8];
                    r_mean_out  <= r_mean[Q15_W-1:0];
                    r_torque    <= torque_nx;
                    r_fault_out <= r_fault;
                    r_latch_out <= n_latch;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_filtered_a    = r_fa;
    assign o_filtered_b    = r_fb;
    assign o_pedal_mean    = r_mean_out;
    assign o_torque_demand = r_torque;
    assign o_sensor_fault  = r_fault_out;
    assign o_brake_fault   = r_latch_out;

endmodule
